// ----- design/qfsp_pkg.sv -----
// Package: result record, parser phase codes and the result builder.
package qfsp_pkg;

    localparam int StaticEntriesDefault = 99;
    localparam logic [12:0] MaxHeadersReset = 13'd100;
    localparam logic [61:0] Max62 = {62{1'b1}};

    // Result kinds
    localparam logic [2:0] KindPrefix  = 3'd0;
    localparam logic [2:0] KindIndexed = 3'd1;
    localparam logic [2:0] KindNameRef = 3'd2;
    localparam logic [2:0] KindName    = 3'd3;
    localparam logic [2:0] KindValue   = 3'd4;
    localparam logic [2:0] KindLine    = 3'd5;
    localparam logic [2:0] KindEnd     = 3'd6;
    localparam logic [2:0] KindError   = 3'd7;

    // Error codes
    localparam logic [2:0] ErrNone    = 3'd0;
    localparam logic [2:0] ErrCount   = 3'd1;
    localparam logic [2:0] ErrDelta   = 3'd2;
    localparam logic [2:0] ErrTrunc   = 3'd3;
    localparam logic [2:0] ErrTooMany = 3'd4;
    localparam logic [2:0] ErrDecomp  = 3'd5;

    // Parser phases
    localparam logic [3:0] PhRic      = 4'd0;
    localparam logic [3:0] PhRicMore  = 4'd1;
    localparam logic [3:0] PhDb       = 4'd2;
    localparam logic [3:0] PhDbMore   = 4'd3;
    localparam logic [3:0] PhLine     = 4'd4;
    localparam logic [3:0] PhIdxMore  = 4'd5;
    localparam logic [3:0] PhNrefMore = 4'd6;
    localparam logic [3:0] PhNlenMore = 4'd7;
    localparam logic [3:0] PhVlen     = 4'd8;
    localparam logic [3:0] PhVlenMore = 4'd9;
    localparam logic [3:0] PhName     = 4'd10;
    localparam logic [3:0] PhValue    = 4'd11;

    // Line flag bits
    localparam int FlN = 0;
    localparam int FlH = 1;
    localparam int FlX = 2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [6:0]  static_index;
        logic [7:0]  data_byte;
        logic        huffman;
        logic        never_index;
        logic        string_last;
        logic [61:0] insert_count_enc;
        logic [61:0] delta_base;
        logic        delta_sign;
        logic [12:0] header_count;
        logic [2:0]  error_code;
        logic        run_last;
    } res_t;

    // Build one result from the parser state at the moment it is raised
    function automatic res_t qfsp_mk(input logic [2:0] kind, input logic [7:0] data,
                                     input logic last, input logic [6:0] hidx,
                                     input logic [2:0] flags, input logic [1:0] lkind,
                                     input logic [12:0] seen, input logic [2:0] err);
        res_t r;
        logic str;
        r = '0;
        str = (kind == KindName) || (kind == KindValue);
        r.kind = kind;
        r.static_index = ((kind == KindIndexed) || (kind == KindNameRef)) ? hidx : 7'd0;
        r.data_byte = str ? data : 8'd0;
        r.huffman = str & flags[FlH];
        r.never_index = (kind >= KindNameRef) && (kind <= KindLine) && (lkind >= 2'd2)
                        && flags[FlN];
        r.string_last = str & last;
        r.header_count = seen;
        r.error_code = (kind == KindError) ? err : ErrNone;
        return r;
    endfunction

endpackage

// ----- design/qfsp_if.sv -----
// Channel interfaces: section bytes in, parser results out, register write.
interface qfsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       section_end;
    modport source (output valid, byte_in, section_end, input ready);
    modport sink (input valid, byte_in, section_end, output ready);
endinterface

interface qfsp_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [6:0]  static_index;
    logic [7:0]  data_byte;
    logic        huffman;
    logic        never_index;
    logic        string_last;
    logic [61:0] insert_count_enc;
    logic [61:0] delta_base;
    logic        delta_sign;
    logic [12:0] header_count;
    logic [2:0]  error_code;
    logic        run_last;
    modport source (output valid, kind, static_index, data_byte, huffman, never_index,
                    string_last, insert_count_enc, delta_base, delta_sign, header_count,
                    error_code, run_last, input ready);
    modport sink (input valid, kind, static_index, data_byte, huffman, never_index,
                  string_last, insert_count_enc, delta_base, delta_sign, header_count,
                  error_code, run_last, output ready);
endinterface

interface qfsp_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- design/qpack_field_section_parser_unit.sv -----
// Top level: streaming field-section parser for the static table.
// One section byte is taken per transaction and is parsed combinationally; the block
// takes a new byte every cycle as long as the result buffer can drain. A byte raises
// zero to three results, which leave one per transaction from a small buffer, so the
// sustained rate is one byte per cycle when each byte gives at most one result; else
// the next byte waits until the last result of the byte before has left. Prefix values,
// indices and string bytes come out raw; Huffman strings are decoded downstream. After
// an error the rest of the section is dropped without results. The header limit is to
// be written through cfg while the block is idle; the block does not enforce this.
module qpack_field_section_parser_unit #(
    parameter int STATIC_ENTRIES = qfsp_pkg::StaticEntriesDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    qfsp_byte_if.sink   bytes,
    qfsp_res_if.source  results,
    qfsp_cfg_if.sink    cfg
);
    import qfsp_pkg::*;

    logic [3:0]  phase_reg, phase_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [1:0]  lkind_reg, lkind_next;
    logic [2:0]  flags_reg, flags_next;
    logic [61:0] left_reg, left_next;
    logic [12:0] seen_reg, seen_next;
    logic [6:0]  hidx_reg, hidx_next;
    logic        errh_reg, errh_next;
    logic [61:0] ric_reg, ric_next;
    logic        sign_reg, sign_next;
    logic [12:0] maxh_reg;

    res_t        rbuf [3];
    logic [1:0]  rcnt;
    logic        free, accept;
    logic [7:0]  b;
    logic        sec_end;
    logic [6:0]  sh;
    logic [63:0] more_val;
    logic        too_long;

    assign b       = bytes.byte_in;
    assign sec_end = bytes.section_end;
    assign bytes.ready = free;
    assign accept  = bytes.valid && free;
    assign cfg.ready = 1'b1;

    // Continuation byte of an integer
    assign sh       = {cnt_reg, 3'b000} - {3'b000, cnt_reg};
    assign more_val = acc_reg + ({57'd0, b[6:0]} << sh);
    assign too_long = (cnt_reg >= 4'd9);

    // One parse step
    always_comb
    begin
        logic [2:0]  err;
        logic        do_idx, do_nlen, do_vlen, do_vend;
        logic [63:0] v;
        logic [61:0] sat;
        res_t        r;

        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        lkind_next = lkind_reg;
        flags_next = flags_reg;
        left_next  = left_reg;
        seen_next  = seen_reg;
        hidx_next  = hidx_reg;
        errh_next  = errh_reg;
        ric_next   = ric_reg;
        sign_next  = sign_reg;
        rcnt       = 2'd0;
        rbuf[0]    = '0;
        rbuf[1]    = '0;
        rbuf[2]    = '0;
        err        = ErrNone;
        do_idx     = 1'b0;
        do_nlen    = 1'b0;
        do_vlen    = 1'b0;
        do_vend    = 1'b0;
        v          = more_val;
        sat        = '0;
        r          = '0;

        if (errh_reg)
        begin
            if (sec_end)
            begin
                errh_next  = 1'b0;
                phase_next = PhRic;
                acc_next   = '0;
                cnt_next   = '0;
                lkind_next = '0;
                flags_next = '0;
                left_next  = '0;
                seen_next  = '0;
            end
        end
        else
        begin
            case (phase_reg)
                PhRic:
                begin
                    acc_next = {56'd0, b};
                    cnt_next = 4'd0;
                    if (b != 8'hFF)
                    begin
                        ric_next   = {54'd0, b};
                        phase_next = PhDb;
                    end
                    else
                        phase_next = PhRicMore;
                end
                PhDb:
                begin
                    sign_next = b[7];
                    acc_next  = {57'd0, b[6:0]};
                    cnt_next  = 4'd0;
                    if (b[6:0] != 7'h7F)
                    begin
                        r = qfsp_mk(KindPrefix, 8'd0, 1'b0, hidx_next, flags_next,
                                    lkind_next, seen_next, ErrNone);
                        r.insert_count_enc = ric_reg;
                        r.delta_base = {55'd0, b[6:0]};
                        r.delta_sign = b[7];
                        rbuf[rcnt] = r;
                        rcnt = rcnt + 2'd1;
                        phase_next = PhLine;
                    end
                    else
                        phase_next = PhDbMore;
                end
                PhRicMore, PhDbMore, PhIdxMore, PhNrefMore, PhNlenMore, PhVlenMore:
                begin
                    if (too_long)
                    begin
                        if (phase_reg == PhRicMore)
                            err = ErrCount;
                        else if (phase_reg == PhDbMore)
                            err = ErrDelta;
                        else
                            err = ErrTrunc;
                    end
                    else
                    begin
                        acc_next = more_val;
                        cnt_next = cnt_reg + 4'd1;
                        if (!b[7])
                        begin
                            case (phase_reg)
                                PhRicMore:
                                begin
                                    ric_next   = more_val[61:0];
                                    phase_next = PhDb;
                                end
                                PhDbMore:
                                begin
                                    r = qfsp_mk(KindPrefix, 8'd0, 1'b0, hidx_next,
                                                flags_next, lkind_next, seen_next, ErrNone);
                                    r.insert_count_enc = ric_reg;
                                    r.delta_base = more_val[61:0];
                                    r.delta_sign = sign_reg;
                                    rbuf[rcnt] = r;
                                    rcnt = rcnt + 2'd1;
                                    phase_next = PhLine;
                                end
                                PhNlenMore: do_nlen = 1'b1;
                                PhVlenMore: do_vlen = 1'b1;
                                default:    do_idx = 1'b1;
                            endcase
                        end
                    end
                end
                PhLine:
                begin
                    cnt_next = 4'd0;
                    if (seen_reg >= maxh_reg)
                        err = ErrTooMany;
                    else if (b[7:5] == 3'b000)
                        err = ErrDecomp;
                    else if (b[7])
                    begin
                        lkind_next = 2'd1;
                        flags_next = {b[6], 2'b00};
                        acc_next   = {58'd0, b[5:0]};
                        v          = acc_next;
                        if (b[5:0] != 6'h3F)
                            do_idx = 1'b1;
                        else
                            phase_next = PhIdxMore;
                    end
                    else if (b[6])
                    begin
                        lkind_next = 2'd2;
                        flags_next = {b[4], 1'b0, b[5]};
                        acc_next   = {60'd0, b[3:0]};
                        v          = acc_next;
                        if (b[3:0] != 4'hF)
                            do_idx = 1'b1;
                        else
                            phase_next = PhNrefMore;
                    end
                    else
                    begin
                        lkind_next = 2'd3;
                        flags_next = {1'b0, b[3], b[4]};
                        acc_next   = {61'd0, b[2:0]};
                        v          = acc_next;
                        if (b[2:0] != 3'h7)
                            do_nlen = 1'b1;
                        else
                            phase_next = PhNlenMore;
                    end
                end
                PhVlen:
                begin
                    flags_next[FlH] = b[7];
                    acc_next = {57'd0, b[6:0]};
                    cnt_next = 4'd0;
                    v        = acc_next;
                    if (b[6:0] != 7'h7F)
                        do_vlen = 1'b1;
                    else
                        phase_next = PhVlenMore;
                end
                PhName:
                begin
                    rbuf[rcnt] = qfsp_mk(KindName, b, left_reg == 62'd1, hidx_next,
                                         flags_next, lkind_next, seen_next, ErrNone);
                    rcnt = rcnt + 2'd1;
                    left_next = left_reg - 62'd1;
                    if (left_reg == 62'd1)
                    begin
                        flags_next[FlH] = 1'b0;
                        phase_next = PhVlen;
                    end
                end
                PhValue:
                begin
                    rbuf[rcnt] = qfsp_mk(KindValue, b, left_reg == 62'd1, hidx_next,
                                         flags_next, lkind_next, seen_next, ErrNone);
                    rcnt = rcnt + 2'd1;
                    left_next = left_reg - 62'd1;
                    if (left_reg == 62'd1)
                        do_vend = 1'b1;
                end
                default:
                    phase_next = PhRic;
            endcase

            // Completed integers
            sat = (v[63:62] != 2'b00) ? Max62 : v[61:0];
            if (do_idx)
            begin
                if (!(flags_next[FlX] && (v < 64'(STATIC_ENTRIES))))
                    err = ErrDecomp;
                else
                begin
                    hidx_next = v[6:0];
                    if (lkind_next == 2'd1)
                    begin
                        rbuf[rcnt] = qfsp_mk(KindIndexed, 8'd0, 1'b0, hidx_next,
                                             flags_next, lkind_next, seen_next, ErrNone);
                        rcnt = rcnt + 2'd1;
                        seen_next = seen_next + 13'd1;
                        rbuf[rcnt] = qfsp_mk(KindLine, 8'd0, 1'b0, hidx_next,
                                             flags_next, lkind_next, seen_next, ErrNone);
                        rcnt = rcnt + 2'd1;
                        phase_next = PhLine;
                    end
                    else
                    begin
                        rbuf[rcnt] = qfsp_mk(KindNameRef, 8'd0, 1'b0, hidx_next,
                                             flags_next, lkind_next, seen_next, ErrNone);
                        rcnt = rcnt + 2'd1;
                        phase_next = PhVlen;
                    end
                end
            end
            if (do_nlen)
            begin
                left_next = sat;
                if (sat == 62'd0)
                begin
                    flags_next[FlX] = 1'b1;
                    phase_next = PhVlen;
                end
                else
                    phase_next = PhName;
            end
            if (do_vlen)
            begin
                left_next = sat;
                if (sat == 62'd0)
                    do_vend = 1'b1;
                else
                    phase_next = PhValue;
            end
            if (do_vend)
            begin
                if ((lkind_next == 2'd3) && flags_next[FlX])
                    err = ErrDecomp;
                else
                begin
                    seen_next = seen_next + 13'd1;
                    rbuf[rcnt] = qfsp_mk(KindLine, 8'd0, 1'b0, hidx_next,
                                         flags_next, lkind_next, seen_next, ErrNone);
                    rcnt = rcnt + 2'd1;
                    phase_next = PhLine;
                end
            end

            // Section end checks
            if ((err == ErrNone) && sec_end)
            begin
                if ((phase_next == PhRic) || (phase_next == PhRicMore))
                    err = ErrCount;
                else if ((phase_next == PhDb) || (phase_next == PhDbMore))
                    err = ErrDelta;
                else if (phase_next != PhLine)
                    err = ErrTrunc;
                else if (seen_next >= maxh_reg)
                    err = ErrTooMany;
                else
                begin
                    rbuf[rcnt] = qfsp_mk(KindEnd, 8'd0, 1'b0, hidx_next,
                                         flags_next, lkind_next, seen_next, ErrNone);
                    rcnt = rcnt + 2'd1;
                end
            end
            if (err != ErrNone)
            begin
                rbuf[rcnt] = qfsp_mk(KindError, 8'd0, 1'b0, hidx_next,
                                     flags_next, lkind_next, seen_next, err);
                rcnt = rcnt + 2'd1;
                if (!sec_end)
                    errh_next = 1'b1;
            end
            if (sec_end)
            begin
                phase_next = PhRic;
                acc_next   = '0;
                cnt_next   = '0;
                lkind_next = '0;
                flags_next = '0;
                left_next  = '0;
                seen_next  = '0;
            end
            if (rcnt != 2'd0)
                rbuf[rcnt - 2'd1].run_last = 1'b1;
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PhRic;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            lkind_reg <= '0;
            flags_reg <= '0;
            left_reg  <= '0;
            seen_reg  <= '0;
            hidx_reg  <= '0;
            errh_reg  <= 1'b0;
            ric_reg   <= '0;
            sign_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            lkind_reg <= lkind_next;
            flags_reg <= flags_next;
            left_reg  <= left_next;
            seen_reg  <= seen_next;
            hidx_reg  <= hidx_next;
            errh_reg  <= errh_next;
            ric_reg   <= ric_next;
            sign_reg  <= sign_next;
        end
    end

    // Header limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            maxh_reg <= MaxHeadersReset;
        else if (cfg.valid && cfg.ready)
            maxh_reg <= cfg.data;
    end

    qfsp_outbuf u_outbuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept && (rcnt != 2'd0)),
        .res_in  (rbuf),
        .res_cnt (rcnt),
        .free    (free),
        .results (results)
    );

endmodule

// ----- design/qfsp_outbuf.sv -----
// Result buffer: holds the up to three results of one byte and hands them out in order.
module qfsp_outbuf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  qfsp_pkg::res_t  res_in [3],
    input  logic [1:0]      res_cnt,
    output logic            free,
    qfsp_res_if.source      results
);
    import qfsp_pkg::*;

    res_t       slot_reg [3];
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] ptr_reg, ptr_next;
    logic       fire, at_last;
    res_t       cur;

    assign cur     = slot_reg[ptr_reg];
    assign fire    = results.valid && results.ready;
    assign at_last = (ptr_reg == (cnt_reg - 2'd1));
    assign free    = (cnt_reg == 2'd0) || (fire && at_last);

    // Output payload
    assign results.valid            = (cnt_reg != 2'd0);
    assign results.kind             = cur.kind;
    assign results.static_index     = cur.static_index;
    assign results.data_byte        = cur.data_byte;
    assign results.huffman          = cur.huffman;
    assign results.never_index      = cur.never_index;
    assign results.string_last      = cur.string_last;
    assign results.insert_count_enc = cur.insert_count_enc;
    assign results.delta_base       = cur.delta_base;
    assign results.delta_sign       = cur.delta_sign;
    assign results.header_count     = cur.header_count;
    assign results.error_code       = cur.error_code;
    assign results.run_last         = cur.run_last;

    // Count and read pointer
    always_comb
    begin
        cnt_next = cnt_reg;
        ptr_next = ptr_reg;
        if (load)
        begin
            cnt_next = res_cnt;
            ptr_next = 2'd0;
        end
        else if (fire)
        begin
            if (at_last)
                cnt_next = 2'd0;
            else
                ptr_next = ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            ptr_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
        end
    end

    // Result slots
    always_ff @(posedge clk)
    begin
        if (load)
            slot_reg <= res_in;
    end

endmodule
